// ----- src/tof_roi_scan_heatmap_unit_macros.svh -----
// Assertion macros shared by the heat-map scan unit.
`ifndef TOF_ROI_SCAN_HEATMAP_UNIT_MACROS_SVH
`define TOF_ROI_SCAN_HEATMAP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced while rst_n is low.
`define TRSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and silenced while rst_n is low.
`define TRSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/trsh_pkg.sv -----
// Types, mode codes and table functions for the heat-map scan unit.
package trsh_pkg;

    // Grid size codes held in the mode register.
    localparam logic [1:0] MODE_GRID16 = 2'd0;
    localparam logic [1:0] MODE_GRID8  = 2'd1;
    localparam logic [1:0] MODE_GRID4  = 2'd2;
    localparam logic [1:0] MODE_GRID1  = 2'd3;
    localparam logic [1:0] ROI_MODE_RESET = MODE_GRID8;

    // Centre used whenever the receive array is not stepped.
    localparam logic [7:0] CENTER_FIXED = 8'd199;

    // Upper bound (exclusive) of a measurable distance.
    localparam logic [15:0] RANGE_LIMIT_MM = 16'd4000;

    typedef struct packed {
        logic [15:0] distance_mm;
        logic        timed_out;
    } item_t;

    typedef struct packed {
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [7:0]  heat_level;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        measurable;
        logic [11:0] display_min_mm;
        logic        shown_valid;
        logic [7:0]  next_center;
        logic        frame_end;
    } result_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Stepped intensity for a measurable distance.
    function automatic logic [7:0] level_for(input logic [11:0] mm);
        logic [7:0] lvl;
        if (mm <= 12'd100)       lvl = 8'd255;
        else if (mm <= 12'd200)  lvl = 8'd230;
        else if (mm <= 12'd300)  lvl = 8'd205;
        else if (mm <= 12'd450)  lvl = 8'd182;
        else if (mm <= 12'd650)  lvl = 8'd162;
        else if (mm <= 12'd900)  lvl = 8'd145;
        else if (mm <= 12'd1200) lvl = 8'd130;
        else if (mm <= 12'd1550) lvl = 8'd118;
        else if (mm <= 12'd1950) lvl = 8'd108;
        else if (mm <= 12'd2350) lvl = 8'd100;
        else if (mm <= 12'd2700) lvl = 8'd94;
        else if (mm <= 12'd3000) lvl = 8'd90;
        else                     lvl = 8'd88;
        return lvl;
    endfunction

    // Heat colour: black to blue, blue to cyan, cyan to yellow, yellow to red.
    function automatic rgb_t heat_colour(input logic [7:0] lvl);
        rgb_t       c;
        logic [7:0] ramp;
        ramp = {lvl[5:0], 2'b00};
        unique case (lvl[7:6])
            2'd0:    c = '{red: 8'd0,   green: 8'd0,          blue: ramp};
            2'd1:    c = '{red: 8'd0,   green: ramp,          blue: 8'd255};
            2'd2:    c = '{red: ramp,   green: 8'd255,        blue: 8'd255 - ramp};
            default: c = '{red: 8'd255, green: 8'd255 - ramp, blue: 8'd0};
        endcase
        return c;
    endfunction

    // Position on the 16-wide receive array of a cell index in the 4x4 grid.
    function automatic logic [3:0] coord_grid4(input logic [1:0] i);
        logic [3:0] c;
        unique case (i)
            2'd0:    c = 4'd2;
            2'd1:    c = 4'd6;
            2'd2:    c = 4'd9;
            default: c = 4'd13;
        endcase
        return c;
    endfunction

    // Receive-array centre number from array column and row.
    function automatic logic [7:0] center_for(input logic [3:0] x16, input logic [3:0] y16);
        logic [7:0] xs;
        logic [7:0] c;
        xs = {1'b0, x16, 3'b000};
        if (!y16[3]) c = 8'd128 + xs + {4'b0000, y16};
        else         c = 8'd127 - xs - {5'b00000, y16[2:0]};
        return c;
    endfunction

endpackage

// ----- src/tof_roi_scan_heatmap_unit.sv -----
// Heat-map scan unit: ranging result in, cell position, colour and minimum out.
`include "tof_roi_scan_heatmap_unit_macros.svh"

// Steps a multizone time-of-flight scan over a square grid of 16, 8, 4 or 1
// cells per side, row by row. Each item on the input channel is one ranging
// result for the current cell; each produces exactly one result item giving
// the cell coordinates, a stepped intensity with its RGB heat colour, the
// measurable flag, the frame minimum (or the last minimum seen when this
// frame has none yet), the receive-array centre to program for the next cell
// and a flag marking the last cell of a frame. A result is measurable when
// there is no timeout and the distance lies between 1 and 3999 mm; otherwise
// its intensity is zero. An accepted item moves from an input register into a
// result register when that is free, and one item is accepted every cycle
// while the result side keeps taking results: the input register and the
// result register enclose a single stage of logic, and the scan and minimum
// state are updated as an item moves into the result register, so the next
// item sees them at once. A write on the configuration port selects the grid
// size, restarts the scan at cell 0 and clears the frame minimum; writes are
// expected only while the unit holds no item. There is no clearing pass after
// reset.
module tof_roi_scan_heatmap_unit
    import trsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,

    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result,

    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    // Input stage.
    logic        in_valid_reg;
    item_t       in_reg;

    // Result stage.
    logic        out_valid_reg;
    result_t     out_reg;

    // Configuration and scan state.
    logic [1:0]  mode_reg;
    logic [7:0]  scan_pos_reg;
    logic [11:0] frame_min_reg;
    logic        frame_has_min_reg;
    logic [11:0] prev_min_reg;
    logic        prev_min_valid_reg;

    // Next values of the state, used when an item advances.
    logic [7:0]  scan_pos_next;
    logic [11:0] frame_min_next;
    logic        frame_has_min_next;
    logic [11:0] prev_min_next;
    logic        prev_min_valid_next;
    result_t     result_next;

    logic        advance;
    logic        item_accept;

    // Working signals of the single logic stage.
    logic        frame_has_min_eff;
    logic        meas;
    logic [11:0] mm;
    logic [7:0]  lvl;
    rgb_t        colour;
    logic [8:0]  pos_inc;
    logic        last;
    logic [3:0]  cx;
    logic [3:0]  cy;
    logic [7:0]  center;

    // The result register is free when empty or being emptied this cycle.
    assign advance     = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready  = !in_valid_reg || advance;
    assign item_accept = item_valid && item_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        mm   = in_reg.distance_mm[11:0];
        meas = !in_reg.timed_out && (in_reg.distance_mm != 16'd0)
               && (in_reg.distance_mm < RANGE_LIMIT_MM);

        // A new frame starts with no minimum, before this cell is counted.
        frame_has_min_eff = (scan_pos_reg != 8'd0) && frame_has_min_reg;

        if (meas && (!frame_has_min_eff || (mm < frame_min_reg))) frame_min_next = mm;
        else                                                        frame_min_next = frame_min_reg;
        frame_has_min_next  = frame_has_min_eff || meas;
        prev_min_next       = meas ? frame_min_next : prev_min_reg;
        prev_min_valid_next = prev_min_valid_reg || meas;

        lvl    = meas ? level_for(mm) : 8'd0;
        colour = heat_colour(lvl);

        // Scan advance; the end of the frame depends on the number of cells.
        pos_inc = {1'b0, scan_pos_reg} + 9'd1;
        unique case (mode_reg)
            MODE_GRID16:
            begin
                last = pos_inc[8];
                cx   = scan_pos_reg[3:0];
                cy   = scan_pos_reg[7:4];
            end
            MODE_GRID8:
            begin
                last = pos_inc[6];
                cx   = {1'b0, scan_pos_reg[2:0]};
                cy   = {1'b0, scan_pos_reg[5:3]};
            end
            MODE_GRID4:
            begin
                last = pos_inc[4];
                cx   = {2'b00, scan_pos_reg[1:0]};
                cy   = {2'b00, scan_pos_reg[3:2]};
            end
            default:
            begin
                last = 1'b1;
                cx   = 4'd0;
                cy   = 4'd0;
            end
        endcase
        scan_pos_next = last ? 8'd0 : pos_inc[7:0];

        // Centre of the next cell on the receive array. The 8x8 grid maps
        // index i to array position 4 + i; the 4x4 grid uses a small table.
        unique case (mode_reg)
            MODE_GRID8:
                center = center_for(4'd4 + {1'b0, scan_pos_next[2:0]},
                                    4'd4 + {1'b0, scan_pos_next[5:3]});
            MODE_GRID4:
                center = center_for(coord_grid4(scan_pos_next[1:0]),
                                    coord_grid4(scan_pos_next[3:2]));
            default:
                center = CENTER_FIXED;
        endcase

        result_next.cell_x      = cx;
        result_next.cell_y      = cy;
        result_next.heat_level  = lvl;
        result_next.red         = colour.red;
        result_next.green       = colour.green;
        result_next.blue        = colour.blue;
        result_next.measurable  = meas;
        result_next.shown_valid = frame_has_min_next || prev_min_valid_next;
        if (frame_has_min_next)       result_next.display_min_mm = frame_min_next;
        else if (prev_min_valid_next) result_next.display_min_mm = prev_min_next;
        else                          result_next.display_min_mm = 12'd0;
        result_next.next_center = center;
        result_next.frame_end   = last;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            mode_reg           <= ROI_MODE_RESET;
            scan_pos_reg       <= 8'd0;
            frame_min_reg      <= 12'd0;
            frame_has_min_reg  <= 1'b0;
            prev_min_reg       <= 12'd0;
            prev_min_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            // A configuration write must arrive only while no item is held; the block does not enforce this.
            priority if (cfg_wr_en)
            begin
                mode_reg          <= cfg_wr_data;
                scan_pos_reg      <= 8'd0;
                frame_has_min_reg <= 1'b0;
            end
            else if (advance)
            begin
                scan_pos_reg       <= scan_pos_next;
                frame_min_reg      <= frame_min_next;
                frame_has_min_reg  <= frame_has_min_next;
                prev_min_reg       <= prev_min_next;
                prev_min_valid_reg <= prev_min_valid_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item_accept)
            in_reg <= item;
        if (advance)
            out_reg <= result_next;
    end

    `TRSH_ASSERT_NOW(a_pos_in_grid,
        (mode_reg == MODE_GRID1) || (mode_reg == MODE_GRID4) || (mode_reg == MODE_GRID8),
        ((mode_reg == MODE_GRID1) && (scan_pos_reg == 8'd0))
        || ((mode_reg == MODE_GRID4) && (scan_pos_reg[7:4] == 4'd0))
        || ((mode_reg == MODE_GRID8) && (scan_pos_reg[7:6] == 2'd0)),
        "scan position beyond the grid")
    `TRSH_ASSERT_NOW(a_level_matches_meas, out_valid_reg,
        out_reg.measurable == (out_reg.heat_level != 8'd0),
        "intensity disagrees with the measurable flag")
    `TRSH_ASSERT_NOW(a_meas_gives_min, out_valid_reg && out_reg.measurable,
        out_reg.shown_valid && (out_reg.display_min_mm != 12'd0),
        "measurable result without a shown minimum")
    `TRSH_ASSERT_NEXT(a_frame_wraps, advance && result_next.frame_end && !cfg_wr_en,
        scan_pos_reg == 8'd0,
        "scan did not return to cell 0 after the last cell")

endmodule

// ----- tb/tof_roi_scan_heatmap_unit_test.sv -----
// Self-checking testbench for the heat-map scan unit, driven through its valid/ready channels.
`timescale 1ns / 100ps

// This testbench drives ranging readings into the unit and checks every result item
// against a predictor of the scan held in this file. The predictor steps a grid position,
// classifies each reading as measurable or not, and maps the distance to a stepped heat
// level and an RGB colour. It also tracks the frame minimum and the last minimum seen.
// It works out the receive-array centre for the next cell from the grid geometry.
//
// The stimulus runs as a set of named tests, called in turn from the main initial block.
// They cover:
//   - readings straight after reset, while no minimum exists yet;
//   - the edges of every heat band and the measurable range;
//   - every grid size, including the single-cell grid where every item ends a frame;
//   - restarting a frame by rewriting the mode register;
//   - the 256-cell grid running past its wrap;
//   - a long stall on the result side that backs the unit up to its input;
//   - random mode changes with random readings.
// Both sides insert random gaps per item in some stretches and run flat out in others.
module tof_roi_scan_heatmap_unit_test;
    import trsh_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid;
    logic       item_ready;
    item_t      item;
    logic       result_valid;
    logic       result_ready;
    result_t    result;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;

    // Predicted results wait here, oldest first, until the unit delivers them.
    result_t     expected_cells [$];
    int unsigned error_count = 0;

    // Random gaps on both channels are only drawn while this is set.
    bit          gaps_enabled = 1'b0;

    // A test sets this to ask the result side for one long hold-off, in cycles.
    int unsigned hold_off_request = 0;

    // Predictor state. It mirrors the scan position, the frame minimum and the last
    // minimum, and it follows the unit's reset values.
    logic [1:0]  grid_mode = ROI_MODE_RESET;
    logic [7:0]  scan_cell = 8'd0;
    logic [11:0] frame_min = 12'd0;
    logic        frame_min_seen = 1'b0;
    logic [11:0] last_min = 12'd0;
    logic        last_min_seen = 1'b0;

    always #2 clk = ~clk;

    tof_roi_scan_heatmap_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned cells_per_side(input logic [1:0] mode);
        int unsigned side;
        unique case (mode)
            MODE_GRID16: side = 16;
            MODE_GRID8:  side = 8;
            MODE_GRID4:  side = 4;
            default:     side = 1;
        endcase
        return side;
    endfunction

    // Stepped intensity for a measurable distance: nearer objects glow hotter.
    function automatic int unsigned heat_step(input int unsigned mm);
        int unsigned lvl;
        if (mm <= 100)       lvl = 255;
        else if (mm <= 200)  lvl = 230;
        else if (mm <= 300)  lvl = 205;
        else if (mm <= 450)  lvl = 182;
        else if (mm <= 650)  lvl = 162;
        else if (mm <= 900)  lvl = 145;
        else if (mm <= 1200) lvl = 130;
        else if (mm <= 1550) lvl = 118;
        else if (mm <= 1950) lvl = 108;
        else if (mm <= 2350) lvl = 100;
        else if (mm <= 2700) lvl = 94;
        else if (mm <= 3000) lvl = 90;
        else                 lvl = 88;
        return lvl;
    endfunction

    // Spreads a grid index across the 16-wide receive array, rounding to nearest.
    function automatic int unsigned array_coord(input int unsigned i, input int unsigned side);
        int unsigned lo;
        int unsigned hi;
        lo = side / 2;
        hi = 15 - lo;
        if (side <= 1 || hi < lo)
            return 7;
        return lo + (i * (hi - lo) + (side - 1) / 2) / (side - 1);
    endfunction

    // Centre numbering: the upper half counts up from 128 and the lower half counts down
    // from 127.
    function automatic logic [7:0] receive_centre(input int unsigned x, input int unsigned y,
                                                  input int unsigned side);
        int unsigned ax;
        int unsigned ay;
        int unsigned c;
        ax = array_coord(x, side);
        ay = array_coord(y, side);
        if (ay < 8) c = 128 + ax * 8 + ay;
        else        c = 127 - ax * 8 - (ay - 8);
        return c[7:0];
    endfunction

    // Works out the result item for one accepted reading and advances the predicted scan.
    function automatic result_t predict_cell_result(input item_t rd);
        result_t     r;
        int unsigned side;
        int unsigned pos;
        int unsigned nxt;
        int unsigned mm;
        int unsigned lvl;
        int unsigned rv;
        int unsigned gv;
        int unsigned bv;
        logic        meas;
        side = cells_per_side(grid_mode);
        pos  = scan_cell;
        mm   = rd.distance_mm;
        lvl  = 0;
        // A new frame forgets its minimum before the first reading is used.
        if (pos == 0)
            frame_min_seen = 1'b0;
        meas = !rd.timed_out && mm > 0 && mm < RANGE_LIMIT_MM;
        if (meas)
        begin
            if (!frame_min_seen || mm < frame_min)
            begin
                frame_min      = mm[11:0];
                frame_min_seen = 1'b1;
            end
            last_min      = frame_min;
            last_min_seen = 1'b1;
            lvl           = heat_step(mm);
        end
        // Four colour bands of 64 levels: black-blue, blue-cyan, cyan-yellow, yellow-red.
        if (lvl < 64)
        begin
            rv = 0;
            gv = 0;
            bv = lvl * 4;
        end
        else if (lvl < 128)
        begin
            rv = 0;
            gv = (lvl - 64) * 4;
            bv = 255;
        end
        else if (lvl < 192)
        begin
            rv = (lvl - 128) * 4;
            gv = 255;
            bv = 255 - (lvl - 128) * 4;
        end
        else
        begin
            rv = 255;
            gv = 255 - (lvl - 192) * 4;
            bv = 0;
        end
        r.cell_x     = 4'(pos % side);
        r.cell_y     = 4'(pos / side);
        r.heat_level = lvl[7:0];
        r.red        = rv[7:0];
        r.green      = gv[7:0];
        r.blue       = bv[7:0];
        r.measurable = meas;
        // With no minimum at all the shown distance reads zero.
        if (frame_min_seen)     r.display_min_mm = frame_min;
        else if (last_min_seen) r.display_min_mm = last_min;
        else                    r.display_min_mm = 12'd0;
        r.shown_valid = frame_min_seen || last_min_seen;
        nxt         = pos + 1;
        r.frame_end = (nxt >= side * side);
        if (r.frame_end)
            nxt = 0;
        scan_cell = nxt[7:0];
        // Only the 8 and 4 grids step the receive array; the others keep it fixed.
        if (side == 16 || side == 1) r.next_center = CENTER_FIXED;
        else                         r.next_center = receive_centre(nxt % side, nxt / side, side);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_error(input string what);
        $display("error at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic check_cell_result(input result_t got);
        result_t want;
        if (expected_cells.size() == 0)
        begin
            report_error("result item arrived with none pending");
        end
        else
        begin
            want = expected_cells.pop_front();
            compare_field("cell_x",      16'(got.cell_x),      16'(want.cell_x));
            compare_field("cell_y",      16'(got.cell_y),      16'(want.cell_y));
            compare_field("heat_level",  16'(got.heat_level),  16'(want.heat_level));
            compare_field("red",         16'(got.red),         16'(want.red));
            compare_field("green",       16'(got.green),       16'(want.green));
            compare_field("blue",        16'(got.blue),        16'(want.blue));
            compare_field("measurable",  16'(got.measurable),  16'(want.measurable));
            compare_field("display_min_mm", 16'(got.display_min_mm),
                          16'(want.display_min_mm));
            compare_field("shown_valid", 16'(got.shown_valid), 16'(want.shown_valid));
            compare_field("next_center", 16'(got.next_center), 16'(want.next_center));
            compare_field("frame_end",   16'(got.frame_end),   16'(want.frame_end));
        end
    endtask

    // Every result handshake is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            check_cell_result(result);
    end

    // Result side: draws a stall before each item, or serves one long hold-off when a test
    // asks for it. Ready is only ever changed once per clock edge.
    initial
    begin : result_sink
        int unsigned stall;
        result_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_request > 0)
            begin
                stall            = hold_off_request;
                hold_off_request = 0;
            end
            else
            begin
                stall = gaps_enabled ? $urandom_range(0, 14) : 0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one reading, holds it until accepted and records its prediction.
    task automatic send_reading(input logic [15:0] mm, input logic timed_out);
        int unsigned gap;
        item_t       rd;
        gap            = gaps_enabled ? $urandom_range(0, 14) : 0;
        rd.distance_mm = mm;
        rd.timed_out   = timed_out;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= rd;
        item_valid <= 1'b1;
        do @(posedge clk); while (!(item_valid && item_ready));
        expected_cells.push_back(predict_cell_result(rd));
    endtask

    // Mostly well-formed readings in range, with some zeros, overflows and timeouts.
    task automatic send_random_reading();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       send_reading(16'd0, 1'b0);
            1:       send_reading(16'($urandom_range(4000, 65535)), 1'b0);
            2:       send_reading(16'($urandom), 1'b0);
            3:       send_reading(16'($urandom), 1'b1);
            default: send_reading(16'($urandom_range(1, 3999)), 1'b0);
        endcase
    endtask

    // Stops offering items and waits until every predicted result has been checked.
    task automatic settle_unit();
        item_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The mode register is written only while the unit is empty.
    task automatic set_grid_mode(input logic [1:0] mode);
        settle_unit();
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        grid_mode      = mode;
        scan_cell      = 8'd0;
        frame_min_seen = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset, in the default 8x8 grid. The first readings cannot be measured,
    // so no minimum exists yet. Then come the measurable limits and every heat band edge.
    task automatic test_readings_after_reset();
        logic [15:0] band_edges [18] = '{16'd3999, 16'd1, 16'd100, 16'd101, 16'd200, 16'd201,
                                         16'd300, 16'd450, 16'd650, 16'd900, 16'd1200,
                                         16'd1550, 16'd1950, 16'd2350, 16'd2700, 16'd3000,
                                         16'd3001, 16'd2};
        gaps_enabled = 1'b0;
        send_reading(16'd0, 1'b1);
        send_reading(16'd0, 1'b0);
        send_reading(RANGE_LIMIT_MM, 1'b0);
        send_reading(16'hFFFF, 1'b0);
        // A timeout spoils a reading that would otherwise be in range.
        send_reading(16'd500, 1'b1);
        foreach (band_edges[k])
            send_reading(band_edges[k], 1'b0);
    endtask

    // Every grid size. In the single-cell grid each item ends a frame, so the shown value
    // falls back on the last minimum whenever a reading cannot be measured. Rewriting the
    // same mode part-way through a frame must restart the scan.
    task automatic test_grid_sizes();
        gaps_enabled = 1'b1;
        set_grid_mode(MODE_GRID1);
        repeat (8) send_random_reading();
        set_grid_mode(MODE_GRID4);
        repeat (20) send_random_reading();
        set_grid_mode(MODE_GRID4);
        repeat (7) send_random_reading();
        set_grid_mode(MODE_GRID8);
        repeat (66) send_random_reading();
    endtask

    // The full 256-cell grid, taken past its wrap back to cell 0. The first half runs with
    // gaps and the rest runs flat out.
    task automatic test_full_grid_wrap();
        set_grid_mode(MODE_GRID16);
        gaps_enabled = 1'b1;
        repeat (130) send_random_reading();
        gaps_enabled = 1'b0;
        repeat (135) send_random_reading();
    endtask

    // The result side holds off for a long stretch while items keep coming. The unit fills
    // up and must stall its input without losing or repeating an item.
    task automatic test_output_stall();
        set_grid_mode(MODE_GRID4);
        gaps_enabled     = 1'b0;
        hold_off_request = 150;
        repeat (30) send_random_reading();
    endtask

    // Random grid sizes with random readings. Gaps are switched on and off between rounds.
    task automatic test_random_modes();
        logic [1:0] mode;
        repeat (6)
        begin
            mode = 2'($urandom_range(MODE_GRID16, MODE_GRID1));
            set_grid_mode(mode);
            gaps_enabled = 1'($urandom_range(0, 1));
            repeat ($urandom_range(12, 30)) send_random_reading();
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial
    begin
        item_valid  <= 1'b0;
        item        <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= ROI_MODE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_readings_after_reset();
        test_grid_sizes();
        test_full_grid_wrap();
        test_output_stall();
        test_random_modes();

        settle_unit();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A correct run takes well under a tenth of this, even with every gap at its longest.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/trsh_pkg.sv
src/tof_roi_scan_heatmap_unit.sv
tb/tof_roi_scan_heatmap_unit_test.sv
